// File: hw/rtl/smpsq_pkg.sv
`timescale 1ns / 1ps

package smpsq_pkg;

   // Largest interval count; larger requests are clamped to it.
   localparam int MAX_INTERVALS = 4096;

   // Field and datapath widths
   localparam int N_W    = 13;                  // interval count
   localparam int H_W    = 48;                  // step width, unsigned Q32.16
   localparam int X_W    = 50;                  // sample abscissa, signed Q34.16 headroom
   localparam int ACC_W  = 78;                  // weighted sum of squares, unsigned Q78.0
   localparam int PROD_W = ACC_W + H_W;         // sum times step width
   localparam int DQ_W   = 96;                  // shared dividend / quotient, whole 16-bit digits
   localparam int DIV3_DIGITS = DQ_W / 16;      // digits in the divide by three
   localparam int REM_W  = N_W + 1;             // divider partial remainder
   localparam int CNT_W  = 13;                  // step counter, holds loop trip counts
   localparam int OP_W   = 4;

   // Datapath operations issued by the microcode
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_LATCH     = 4'd1;
   localparam logic [OP_W-1:0] OP_DIVH_INIT = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd3;
   localparam logic [OP_W-1:0] OP_SMP_INIT  = 4'd4;
   localparam logic [OP_W-1:0] OP_SMP_ISSUE = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_INIT  = 4'd6;
   localparam logic [OP_W-1:0] OP_MUL_STEP  = 4'd7;
   localparam logic [OP_W-1:0] OP_DIV3_INIT = 4'd8;
   localparam logic [OP_W-1:0] OP_EMIT      = 4'd9;
   localparam logic [OP_W-1:0] OP_REJECT    = 4'd10;
   localparam logic [OP_W-1:0] OP_DIV3_STEP = 4'd11;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ORDER = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   localparam logic signed [63:0] INTEGRAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic [N_W-1:0]     interval_count;
   } req_type;

   typedef struct packed {
      logic signed [63:0] integral;
      logic [1:0]         status;
   } rsp_type;

   // Sequencer to datapath
   typedef struct packed {
      logic            idle;
      logic [OP_W-1:0] op;
   } dp_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic           bad;
      logic [N_W-1:0] n;
   } seq_stat_type;

endpackage

// File: hw/rtl/smpsq_sequencer.sv
`timescale 1ns / 1ps

module smpsq_sequencer import smpsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  seq_stat_type stat,
   output dp_ctrl_type  ctrl
);

   localparam int PC_W = 4;

   // Program addresses
   localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [PC_W-1:0] STEP_CHECK   = 4'd1;
   localparam logic [PC_W-1:0] STEP_DIVH    = 4'd2;
   localparam logic [PC_W-1:0] STEP_SETUP   = 4'd3;
   localparam logic [PC_W-1:0] STEP_SAMPLE  = 4'd4;
   localparam logic [PC_W-1:0] STEP_DRAIN0  = 4'd5;
   localparam logic [PC_W-1:0] STEP_DRAIN   = 4'd6;
   localparam logic [PC_W-1:0] STEP_MULINIT = 4'd7;
   localparam logic [PC_W-1:0] STEP_MUL     = 4'd8;
   localparam logic [PC_W-1:0] STEP_D3INIT  = 4'd9;
   localparam logic [PC_W-1:0] STEP_D3      = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT    = 4'd11;
   localparam logic [PC_W-1:0] STEP_REJ     = 4'd12;

   // Jump conditions
   localparam logic [2:0] COND_NEXT   = 3'd0;
   localparam logic [2:0] COND_ALWAYS = 3'd1;
   localparam logic [2:0] COND_NOSTRT = 3'd2;
   localparam logic [2:0] COND_BAD    = 3'd3;
   localparam logic [2:0] COND_CNT    = 3'd4;

   // Counter load sources
   localparam logic [2:0] CNT_NONE    = 3'd0;
   localparam logic [2:0] CNT_DIVH    = 3'd1;
   localparam logic [2:0] CNT_SAMPLES = 3'd2;
   localparam logic [2:0] CNT_DRAIN   = 3'd3;
   localparam logic [2:0] CNT_MUL     = 3'd4;
   localparam logic [2:0] CNT_DIV3    = 3'd5;

   typedef struct packed {
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
      logic [2:0]      cnt_src;
      logic [OP_W-1:0] op;
   } uword_type;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   uword_type        uw;
   logic             take;

   // Control store
   always_comb begin
      case (pc_ff)
         STEP_IDLE:    uw = '{COND_NOSTRT, STEP_IDLE,    CNT_NONE,    OP_LATCH};
         STEP_CHECK:   uw = '{COND_BAD,    STEP_REJ,     CNT_DIVH,    OP_DIVH_INIT};
         STEP_DIVH:    uw = '{COND_CNT,    STEP_DIVH,    CNT_NONE,    OP_DIV_STEP};
         STEP_SETUP:   uw = '{COND_NEXT,   STEP_IDLE,    CNT_SAMPLES, OP_SMP_INIT};
         STEP_SAMPLE:  uw = '{COND_CNT,    STEP_SAMPLE,  CNT_NONE,    OP_SMP_ISSUE};
         STEP_DRAIN0:  uw = '{COND_NEXT,   STEP_IDLE,    CNT_DRAIN,   OP_NOP};
         STEP_DRAIN:   uw = '{COND_CNT,    STEP_DRAIN,   CNT_NONE,    OP_NOP};
         STEP_MULINIT: uw = '{COND_NEXT,   STEP_IDLE,    CNT_MUL,     OP_MUL_INIT};
         STEP_MUL:     uw = '{COND_CNT,    STEP_MUL,     CNT_NONE,    OP_MUL_STEP};
         STEP_D3INIT:  uw = '{COND_NEXT,   STEP_IDLE,    CNT_DIV3,    OP_DIV3_INIT};
         STEP_D3:      uw = '{COND_CNT,    STEP_D3,      CNT_NONE,    OP_DIV3_STEP};
         STEP_EMIT:    uw = '{COND_ALWAYS, STEP_IDLE,    CNT_NONE,    OP_EMIT};
         STEP_REJ:     uw = '{COND_ALWAYS, STEP_IDLE,    CNT_NONE,    OP_REJECT};
         default:      uw = '{COND_ALWAYS, STEP_IDLE,    CNT_NONE,    OP_NOP};
      endcase
   end

   always_comb begin
      case (uw.cond)
         COND_NEXT:   take = 1'b0;
         COND_ALWAYS: take = 1'b1;
         COND_NOSTRT: take = !start;
         COND_BAD:    take = stat.bad;
         COND_CNT:    take = (cnt_ff != '0);
         default:     take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = take ? uw.target : pc_ff + 1'b1;
   end

   // Load a trip count, or count down while looping
   always_comb begin
      cnt_in = cnt_ff;
      case (uw.cnt_src)
         CNT_DIVH:    cnt_in = CNT_W'(H_W - 1);
         CNT_SAMPLES: cnt_in = CNT_W'(stat.n);
         CNT_DRAIN:   cnt_in = CNT_W'(1);
         CNT_MUL:     cnt_in = CNT_W'(H_W - 1);
         CNT_DIV3:    cnt_in = CNT_W'(DIV3_DIGITS - 1);
         default: begin
            if (uw.cond == COND_CNT && cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign ctrl.idle = (pc_ff == STEP_IDLE);
   assign ctrl.op   = uw.op;

endmodule

// File: hw/rtl/smpsq_datapath.sv
`timescale 1ns / 1ps

module smpsq_datapath import smpsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  dp_ctrl_type  ctrl,
   input  req_type      req_data,
   output seq_stat_type stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   // Weight codes double as left-shift amounts
   localparam logic [1:0] W_ONE  = 2'd0;
   localparam logic [1:0] W_TWO  = 2'd1;
   localparam logic [1:0] W_FOUR = 2'd2;

   localparam logic [N_W-1:0] N_MAX = N_W'(MAX_INTERVALS);
   localparam int             SX_W  = X_W - 16;

   // ceil(2^19 / 3): exact floor divide by three for dividends below 2^18
   localparam logic [17:0]    RECIP3 = 18'h2AAAB;

   logic signed [31:0]       a_ff, a_in, b_ff, b_in;
   logic [N_W-1:0]           n_ff, n_in;
   logic [DQ_W-1:0]          dq_ff, dq_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [N_W-1:0]           dvsr_ff, dvsr_in;
   logic [H_W-1:0]           h_ff, h_in, offs_ff, offs_in;
   logic [N_W-1:0]           idx_ff, idx_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic [31:0]              mag_ff, mag_in;
   logic [63:0]              sq_ff, sq_in;
   logic [1:0]               w1_ff, w1_in, w2_ff, w3_ff;
   logic                     v1_ff, v1_in, v2_ff, v3_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [32:0]              diff_w;
   logic [REM_W-1:0]         trial_w, trial_sub_w;
   logic                     ge_w;
   logic [SX_W-1:0]          sx_w, sx_neg_w;
   logic [ACC_W-1:0]         addend_w;
   logic [ACC_W:0]           psum_w;
   logic                     sat_w;
   logic [N_W-1:0]           n_clamp_w;
   logic [17:0]              d3_cur_w;
   logic [35:0]              d3_prod_w;
   logic [15:0]              d3_q_w;
   logic [17:0]              d3_r_w;

   assign diff_w      = {b_ff[31], b_ff} - {a_ff[31], a_ff};
   assign trial_w     = {rem_ff[REM_W-2:0], dq_ff[DQ_W-1]};
   assign ge_w        = (trial_w >= {1'b0, dvsr_ff});
   assign trial_sub_w = trial_w - {1'b0, dvsr_ff};
   assign sx_w        = x_ff[X_W-1:16];
   assign sx_neg_w    = ~sx_w + 1'b1;
   assign addend_w    = prod_ff[0] ? acc_ff : '0;
   assign psum_w      = {1'b0, prod_ff[PROD_W-1:H_W]} + {1'b0, addend_w};
   assign sat_w       = |dq_ff[DQ_W-1:63];

   // Divide by three one 16-bit digit at a time, carrying the remainder
   assign d3_cur_w  = {rem_ff[1:0], dq_ff[DQ_W-1:DQ_W-16]};
   assign d3_prod_w = d3_cur_w * RECIP3;
   assign d3_q_w    = d3_prod_w[34:19];
   assign d3_r_w    = d3_cur_w - {1'b0, d3_q_w, 1'b0} - {2'b0, d3_q_w};

   always_comb begin
      if (req_data.interval_count == '0) begin
         n_clamp_w = N_W'(1);
      end else if (req_data.interval_count > N_MAX) begin
         n_clamp_w = N_MAX;
      end else begin
         n_clamp_w = req_data.interval_count;
      end
   end

   // Operand latch, step-width divider, sample issue, multiplier and divide by three
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      h_in    = h_ff;
      offs_in = offs_ff;
      idx_in  = idx_ff;
      prod_in = prod_ff;
      x_in    = x_ff;
      w1_in   = w1_ff;
      v1_in   = 1'b0;
      case (ctrl.op)
         OP_LATCH: begin
            if (start) begin
               a_in = req_data.lower_bound;
               b_in = req_data.upper_bound;
               n_in = n_clamp_w;
            end
         end
         OP_DIVH_INIT: begin
            dq_in   = {diff_w[31:0], 16'b0, (DQ_W - H_W)'(0)};
            rem_in  = '0;
            dvsr_in = n_ff;
         end
         OP_DIV_STEP: begin
            rem_in = ge_w ? trial_sub_w : trial_w;
            dq_in  = {dq_ff[DQ_W-2:0], ge_w};
         end
         OP_SMP_INIT: begin
            h_in    = dq_ff[H_W-1:0];
            offs_in = '0;
            idx_in  = '0;
         end
         OP_SMP_ISSUE: begin
            // offset wraps only after the last sample, where it is unused
            x_in    = {{(X_W - 48){a_ff[31]}}, a_ff, 16'b0}
                      + {{(X_W - H_W){1'b0}}, offs_ff};
            v1_in   = 1'b1;
            offs_in = offs_ff + h_ff;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == '0 || idx_ff == n_ff) begin
               w1_in = W_ONE;
            end else if (idx_ff[0]) begin
               w1_in = W_FOUR;
            end else begin
               w1_in = W_TWO;
            end
         end
         OP_MUL_INIT: begin
            prod_in = {ACC_W'(0), h_ff};
         end
         OP_MUL_STEP: begin
            prod_in = {psum_w, prod_ff[H_W-1:1]};
         end
         OP_DIV3_INIT: begin
            dq_in  = DQ_W'(prod_ff[PROD_W-1:32]);
            rem_in = '0;
         end
         OP_DIV3_STEP: begin
            rem_in = REM_W'(d3_r_w[1:0]);
            dq_in  = {dq_ff[DQ_W-17:0], d3_q_w};
         end
         default: begin
         end
      endcase
   end

   // Floor to a signed Q34.0 integer, then take the magnitude
   assign mag_in = sx_w[SX_W-1] ? sx_neg_w[31:0] : sx_w[31:0];
   assign sq_in  = mag_ff * mag_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.op == OP_SMP_INIT) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_ff + (ACC_W'(sq_ff) << w3_ff);
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (ctrl.op)
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            if (sat_w) begin
               rsp_in.integral = INTEGRAL_MAX;
               rsp_in.status   = ST_SAT;
            end else begin
               rsp_in.integral = {1'b0, dq_ff[62:0]};
               rsp_in.status   = ST_OK;
            end
         end
         OP_REJECT: begin
            rsp_valid_in    = 1'b1;
            rsp_in.integral = '0;
            rsp_in.status   = ST_ORDER;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      h_ff    <= h_in;
      offs_ff <= offs_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      w1_ff   <= w1_in;
      mag_ff  <= mag_in;
      w2_ff   <= w1_ff;
      sq_ff   <= sq_in;
      w3_ff   <= w2_ff;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign stat.bad  = !(a_ff < b_ff);
   assign stat.n    = n_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/simpson_integral_of_square_top.sv
`timescale 1ns / 1ps
// A valid request (lower < upper) yields its result strobe after the bit-serial h divide,
// the one-sample-per-cycle Simpson loop, the bit-serial multiply and a six-digit divide by 3;
// a rejected request yields it after the order check. A new request is accepted only while
// the sequencer is idle, so the block works on one request at a time.
// Reset: synchronous, active high; returns the sequencer to idle and drops the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.

module simpson_integral_of_square_top import smpsq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Control path: microcode sequencer steps the program
   //   idle -> check order (else reject) -> divide (b-a)<<16 by n -> n+1 sample issues ->
   //   drain sample pipeline -> shift-add multiply by h -> divide by three -> emit.
   // Data path: a restoring divider for h, a four-stage sample/square/accumulate
   // pipeline, a bit-serial multiplier and a 16-bit-digit reciprocal divide by three.
   dp_ctrl_type  ctrl;
   seq_stat_type stat;

   smpsq_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   smpsq_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Hold busy through the whole program; drop it when the sequencer returns idle
   assign busy = !ctrl.idle;

`ifndef SYNTHESIS
   // A result appears just as the block returns idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted request occupies the block on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // Rejected order returns zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_ORDER) |-> (rsp_data.integral == '0))
      else $error("rejected request with nonzero integral");

   // Saturated result carries the largest value
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_SAT) |-> (rsp_data.integral == INTEGRAL_MAX))
      else $error("saturated result not at maximum");
`endif

endmodule
